[rtl/core/complex_arithmetic_unit_assert.svh]
// Assertion macros for the complex arithmetic unit.
// Used by modules that hold concurrent checks; expects clk_i and rst_ni in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cau_pkg.sv]
// Package for the complex arithmetic unit: item types, operation codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  localparam int CAU_WORD_BITS = 32;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_EQ  = 3'd4,
    KIND_NE  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]   kind;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic         compare_true;
    logic         div_zero;
    logic         saturated;
  } cau_out_t;

  // control that rides along with each item
  typedef struct packed {
    logic [2:0] kind;
    logic       eq;
    logic       bz;
  } cau_ctrl_t;

endpackage

[rtl/core/complex_arithmetic_unit.sv]
// One item per cycle while the output is not stalled; three front stages, a clamp/setup stage,
// one divider stage per quotient bit and the output register.
// A stall at the output while a result is valid freezes the whole pipeline, which then
// stalls the input.
// Reset clears all valid bits; the pipeline is empty after reset.
// Depends on cau_pkg, cau_front, cau_divider and complex_arithmetic_unit_assert.svh.
`timescale 1ns / 1ps

`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS,
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cau_pkg::cau_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cau_pkg::cau_out_t out_item_o
);

  localparam int W = WORD_BITS;

  logic                          en;
  logic                          f_valid;
  cau_pkg::cau_ctrl_t            f_ctrl;
  logic signed [2*W:0]           f_xr, f_xi;
  logic [2*W-1:0]                f_den;
  logic                          d_valid;
  cau_pkg::cau_ctrl_t            d_ctrl;
  logic [W-1:0]                  d_pr, d_pi, d_qr, d_qi;
  logic                          d_psat, d_qsat;
  logic [W-1:0]                  sel_r, sel_i;
  cau_pkg::cau_out_t             out_d, out_q;
  logic                          out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  cau_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .item_i (in_item_i),
    .valid_o(f_valid),
    .ctrl_o (f_ctrl),
    .xr_o   (f_xr),
    .xi_o   (f_xi),
    .den_o  (f_den)
  );

  cau_divider #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (f_valid),
    .ctrl_i    (f_ctrl),
    .xr_i      (f_xr),
    .xi_i      (f_xi),
    .den_i     (f_den),
    .valid_o   (d_valid),
    .ctrl_o    (d_ctrl),
    .pass_r_o  (d_pr),
    .pass_i_o  (d_pi),
    .pass_sat_o(d_psat),
    .div_r_o   (d_qr),
    .div_i_o   (d_qi),
    .div_sat_o (d_qsat)
  );

  always_comb begin
    sel_r              = '0;
    sel_i              = '0;
    out_d.compare_true = 1'b0;
    out_d.div_zero     = 1'b0;
    out_d.saturated    = 1'b0;
    unique case (d_ctrl.kind) inside
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_MUL: begin
        sel_r           = d_pr;
        sel_i           = d_pi;
        out_d.saturated = d_psat;
      end
      cau_pkg::KIND_DIV: begin
        if (d_ctrl.bz) begin
          out_d.div_zero = 1'b1;
        end else begin
          sel_r           = d_qr;
          sel_i           = d_qi;
          out_d.saturated = d_qsat;
        end
      end
      cau_pkg::KIND_EQ: out_d.compare_true = d_ctrl.eq;
      cau_pkg::KIND_NE: out_d.compare_true = !d_ctrl.eq;
      default: ;
    endcase
    out_d.res_real = 32'($signed(sel_r));
    out_d.res_imag = 32'($signed(sel_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CAU_ASSERT_IMPL(a_dz_clean, out_valid_o && out_item_o.div_zero,
    out_item_o.res_real == '0 && out_item_o.res_imag == '0 && !out_item_o.saturated,
    "divide by zero item carries a nonzero result")
  `CAU_ASSERT_IMPL(a_cmp_clean, out_valid_o && out_item_o.compare_true,
    out_item_o.res_real == '0 && out_item_o.res_imag == '0 && !out_item_o.div_zero,
    "compare item carries arithmetic result")
  `CAU_ASSERT_IMPL(a_stall_src, !out_stall_i, !in_stall_o,
    "input stalled without output backpressure")
  `CAU_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o),
    "stalled result changed")

endmodule

[rtl/core/cau_front.sv]
// Front end: operand capture, six products, and the real/imag sums per operation.
// Three register stages. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cau_pkg::cau_in_t   item_i,
  output logic               valid_o,
  output cau_pkg::cau_ctrl_t ctrl_o,
  output logic signed [2*WORD_BITS:0] xr_o,
  output logic signed [2*WORD_BITS:0] xi_o,
  output logic [2*WORD_BITS-1:0]      den_o
);

  localparam int W  = WORD_BITS;
  localparam int LW = W + 1;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;

  // stage A
  logic                va_q;
  logic [2:0]          ka_q;
  logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;
  // stage B
  logic                 vb_q;
  logic [2:0]           kb_q;
  logic                 eqb_q, bzb_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_b2_q;
  logic signed [LW-1:0] lin_r_q, lin_i_q;
  logic signed [LW-1:0] lin_r_d, lin_i_d;
  // stage C
  logic                 vc_q;
  cau_pkg::cau_ctrl_t   ctrl_q;
  logic signed [XW-1:0] xr_q, xi_q, xr_d, xi_d;
  logic [PW-1:0]        den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_comb begin
    if (ka_q == cau_pkg::KIND_SUB) begin
      lin_r_d = LW'(ar_q) - LW'(br_q);
      lin_i_d = LW'(ai_q) - LW'(bi_q);
    end else begin
      lin_r_d = LW'(ar_q) + LW'(br_q);
      lin_i_d = LW'(ai_q) + LW'(bi_q);
    end
  end

  always_comb begin
    case (kb_q)
      cau_pkg::KIND_MUL: begin
        xr_d = XW'(p_rr_q) - XW'(p_ii_q);
        xi_d = XW'(p_ri_q) + XW'(p_ir_q);
      end
      cau_pkg::KIND_DIV: begin
        xr_d = XW'(p_rr_q) + XW'(p_ii_q);
        xi_d = XW'(p_ir_q) - XW'(p_ri_q);
      end
      default: begin
        xr_d = XW'(lin_r_q);
        xi_d = XW'(lin_i_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ka_q    <= item_i.kind;
      ar_q    <= W'(item_i.a_real);
      ai_q    <= W'(item_i.a_imag);
      br_q    <= W'(item_i.b_real);
      bi_q    <= W'(item_i.b_imag);

      kb_q    <= ka_q;
      eqb_q   <= (ar_q == br_q) && (ai_q == bi_q);
      bzb_q   <= (br_q == '0) && (bi_q == '0);
      p_rr_q  <= PW'(ar_q) * PW'(br_q);
      p_ii_q  <= PW'(ai_q) * PW'(bi_q);
      p_ri_q  <= PW'(ar_q) * PW'(bi_q);
      p_ir_q  <= PW'(ai_q) * PW'(br_q);
      p_bb_q  <= PW'(br_q) * PW'(br_q);
      p_b2_q  <= PW'(bi_q) * PW'(bi_q);
      lin_r_q <= lin_r_d;
      lin_i_q <= lin_i_d;

      ctrl_q.kind <= kb_q;
      ctrl_q.eq   <= eqb_q;
      ctrl_q.bz   <= bzb_q;
      xr_q        <= xr_d;
      xi_q        <= xi_d;
      den_q       <= $unsigned(p_bb_q) + $unsigned(p_b2_q);
    end
  end

  assign valid_o = vc_q;
  assign ctrl_o  = ctrl_q;
  assign xr_o    = xr_q;
  assign xi_o    = xi_q;
  assign den_o   = den_q;

endmodule

[rtl/core/cau_divider.sv]
// Back end: clamp of sums and products, then a restoring divider with one
// quotient bit per stage for both parts. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_divider #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS,
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cau_pkg::cau_ctrl_t ctrl_i,
  input  logic signed [2*WORD_BITS:0] xr_i,
  input  logic signed [2*WORD_BITS:0] xi_i,
  input  logic [2*WORD_BITS-1:0]      den_i,
  output logic               valid_o,
  output cau_pkg::cau_ctrl_t ctrl_o,
  output logic [WORD_BITS-1:0] pass_r_o,
  output logic [WORD_BITS-1:0] pass_i_o,
  output logic               pass_sat_o,
  output logic [WORD_BITS-1:0] div_r_o,
  output logic [WORD_BITS-1:0] div_i_o,
  output logic               div_sat_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;
  localparam int NW = PW + F;
  localparam int HW = W + F;
  localparam int CW = (HW > PW) ? HW : PW;

  // clamp of the non-divide path
  logic signed [XW-1:0] yr, yi;
  logic                 sat_r, sat_i;
  logic [W-1:0]         cl_r, cl_i;
  // divide setup
  logic [XW-1:0] mag_r_x, mag_i_x;
  logic [NW-1:0] num_r, num_i;
  logic [CW-1:0] hi_r, hi_i, den_x;

  // stage 0 is the setup register, stage k+1 follows quotient step k
  logic               v_q     [0:W];
  cau_pkg::cau_ctrl_t ctrl_q  [0:W];
  logic [W-1:0]       pr_q    [0:W];
  logic [W-1:0]       pi_q    [0:W];
  logic               psat_q  [0:W];
  logic               neg_r_q [0:W];
  logic               neg_i_q [0:W];
  logic               ovf_r_q [0:W];
  logic               ovf_i_q [0:W];
  logic [PW-1:0]      rem_r_q [0:W];
  logic [PW-1:0]      rem_i_q [0:W];
  logic [W-1:0]       low_r_q [0:W];
  logic [W-1:0]       low_i_q [0:W];
  logic [W-1:0]       q_r_q   [0:W];
  logic [W-1:0]       q_i_q   [0:W];
  logic [PW-1:0]      den_q   [0:W];

  always_comb begin
    yr    = (ctrl_i.kind == cau_pkg::KIND_MUL) ? (xr_i >>> F) : xr_i;
    yi    = (ctrl_i.kind == cau_pkg::KIND_MUL) ? (xi_i >>> F) : xi_i;
    sat_r = (yr[XW-1:W-1] != '0) && (yr[XW-1:W-1] != '1);
    sat_i = (yi[XW-1:W-1] != '0) && (yi[XW-1:W-1] != '1);
    cl_r  = sat_r ? {yr[XW-1], {(W-1){~yr[XW-1]}}} : yr[W-1:0];
    cl_i  = sat_i ? {yi[XW-1], {(W-1){~yi[XW-1]}}} : yi[W-1:0];

    mag_r_x = xr_i[XW-1] ? $unsigned(-xr_i) : $unsigned(xr_i);
    mag_i_x = xi_i[XW-1] ? $unsigned(-xi_i) : $unsigned(xi_i);
    num_r   = {mag_r_x[PW-1:0], {F{1'b0}}};
    num_i   = {mag_i_x[PW-1:0], {F{1'b0}}};
    hi_r    = CW'(num_r[NW-1:W]);
    hi_i    = CW'(num_i[NW-1:W]);
    den_x   = CW'(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q[0]  <= ctrl_i;
      pr_q[0]    <= cl_r;
      pi_q[0]    <= cl_i;
      psat_q[0]  <= sat_r | sat_i;
      neg_r_q[0] <= xr_i[XW-1];
      neg_i_q[0] <= xi_i[XW-1];
      // quotient of 2^W or more can only clamp
      ovf_r_q[0] <= hi_r >= den_x;
      ovf_i_q[0] <= hi_i >= den_x;
      rem_r_q[0] <= hi_r[PW-1:0];
      rem_i_q[0] <= hi_i[PW-1:0];
      low_r_q[0] <= num_r[W-1:0];
      low_i_q[0] <= num_i[W-1:0];
      q_r_q[0]   <= '0;
      q_i_q[0]   <= '0;
      den_q[0]   <= den_i;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [PW:0] t_r, t_i, d_r, d_i;
    logic        ge_r, ge_i;

    always_comb begin
      t_r  = {rem_r_q[k], low_r_q[k][W-1]};
      t_i  = {rem_i_q[k], low_i_q[k][W-1]};
      ge_r = t_r >= {1'b0, den_q[k]};
      ge_i = t_i >= {1'b0, den_q[k]};
      d_r  = ge_r ? (t_r - {1'b0, den_q[k]}) : t_r;
      d_i  = ge_i ? (t_i - {1'b0, den_q[k]}) : t_i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[k+1]  <= ctrl_q[k];
        pr_q[k+1]    <= pr_q[k];
        pi_q[k+1]    <= pi_q[k];
        psat_q[k+1]  <= psat_q[k];
        neg_r_q[k+1] <= neg_r_q[k];
        neg_i_q[k+1] <= neg_i_q[k];
        ovf_r_q[k+1] <= ovf_r_q[k];
        ovf_i_q[k+1] <= ovf_i_q[k];
        rem_r_q[k+1] <= d_r[PW-1:0];
        rem_i_q[k+1] <= d_i[PW-1:0];
        low_r_q[k+1] <= {low_r_q[k][W-2:0], 1'b0};
        low_i_q[k+1] <= {low_i_q[k][W-2:0], 1'b0};
        q_r_q[k+1]   <= {q_r_q[k][W-2:0], ge_r};
        q_i_q[k+1]   <= {q_i_q[k][W-2:0], ge_i};
        den_q[k+1]   <= den_q[k];
      end
    end
  end

  // sign and clamp of the quotient magnitudes
  logic [W-1:0] lim_r, lim_i, val_r, val_i;
  logic         qs_r, qs_i;

  always_comb begin
    lim_r = {neg_r_q[W], {(W-1){~neg_r_q[W]}}};
    lim_i = {neg_i_q[W], {(W-1){~neg_i_q[W]}}};
    qs_r  = ovf_r_q[W] || (q_r_q[W] > lim_r);
    qs_i  = ovf_i_q[W] || (q_i_q[W] > lim_i);
    val_r = qs_r ? lim_r : q_r_q[W];
    val_i = qs_i ? lim_i : q_i_q[W];
  end

  assign valid_o    = v_q[W];
  assign ctrl_o     = ctrl_q[W];
  assign pass_r_o   = pr_q[W];
  assign pass_i_o   = pi_q[W];
  assign pass_sat_o = psat_q[W];
  assign div_r_o    = neg_r_q[W] ? (~val_r + 1'b1) : val_r;
  assign div_i_o    = neg_i_q[W] ? (~val_i + 1'b1) : val_i;
  assign div_sat_o  = qs_r | qs_i;

endmodule

[tb/sv/complex_arithmetic_unit_tb.sv]
// Testbench for complex_arithmetic_unit: directed and random items, random input bursts
// and output stalls, results checked in order against an in-bench Q16.16 predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

  localparam int LATENCY = cau_pkg::CAU_WORD_BITS + 5;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  cau_pkg::cau_in_t  in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  cau_pkg::cau_out_t out_item_o;

  complex_arithmetic_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cau_pkg::cau_out_t expected_results[$];
  int                mismatches = 0;
  int                burst_left = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit sat);
    if (v > 128'(WMAX)) begin
      sat = 1'b1;
      return WMAX;
    end else if (v < 128'(WMIN)) begin
      sat = 1'b1;
      return WMIN;
    end
    return v[31:0];
  endfunction

  // Quotient of the conjugate numerator: scaled by 2^16, truncated toward zero.
  function automatic logic signed [31:0] scaled_quot(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout bit sat);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (num < 0) ? -num : num;
    q = (m <<< cau_pkg::CAU_FRAC_BITS) / den;
    if (num < 0) q = -q;
    return clamp32(q, sat);
  endfunction

  function automatic cau_pkg::cau_out_t complex_result(input cau_pkg::cau_in_t x);
    cau_pkg::cau_out_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, den;
    r   = '0;
    sat = 1'b0;
    ar = x.a_real; ai = x.a_imag; br = x.b_real; bi = x.b_imag;
    case (x.kind)
      cau_pkg::KIND_ADD: begin
        r.res_real = clamp32(ar + br, sat);
        r.res_imag = clamp32(ai + bi, sat);
      end
      cau_pkg::KIND_SUB: begin
        r.res_real = clamp32(ar - br, sat);
        r.res_imag = clamp32(ai - bi, sat);
      end
      cau_pkg::KIND_MUL: begin
        r.res_real = clamp32((ar * br - ai * bi) >>> cau_pkg::CAU_FRAC_BITS, sat);
        r.res_imag = clamp32((ar * bi + ai * br) >>> cau_pkg::CAU_FRAC_BITS, sat);
      end
      cau_pkg::KIND_DIV: begin
        if (br == 0 && bi == 0) begin
          r.div_zero = 1'b1;
        end else begin
          den = br * br + bi * bi;
          r.res_real = scaled_quot(ar * br + ai * bi, den, sat);
          r.res_imag = scaled_quot(ai * br - ar * bi, den, sat);
        end
      end
      cau_pkg::KIND_EQ: r.compare_true = (ar == br) && (ai == bi);
      cau_pkg::KIND_NE: r.compare_true = !((ar == br) && (ai == bi));
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  // Queue on input accept, check on output accept.
  always @(posedge clk_i) begin
    cau_pkg::cau_out_t want;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_results.push_back(complex_result(in_item_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item %h", out_item_o);
      end else begin
        want = expected_results.pop_front();
        if (want.res_real !== out_item_o.res_real || want.res_imag !== out_item_o.res_imag ||
            want.compare_true !== out_item_o.compare_true ||
            want.div_zero !== out_item_o.div_zero || want.saturated !== out_item_o.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp re=%h im=%h cmp=%b dz=%b sat=%b  got re=%h im=%h cmp=%b dz=%b sat=%b",
                     want.res_real, want.res_imag, want.compare_true, want.div_zero,
                     want.saturated, out_item_o.res_real, out_item_o.res_imag,
                     out_item_o.compare_true, out_item_o.div_zero, out_item_o.saturated);
        end
      end
    end
  end

  // Output stall pattern: one of four modes, chosen anew at random.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      2: out_stall_i <= ($urandom_range(0, 4) != 0);
      default: out_stall_i <= (stall_phase % 4 == 0);
    endcase
  end

  task automatic send_item(input cau_pkg::cau_in_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic cau_pkg::cau_in_t make_item(input logic [2:0] k, input logic [31:0] ar,
                                                 input logic [31:0] ai, input logic [31:0] br,
                                                 input logic [31:0] bi);
    cau_pkg::cau_in_t x;
    x.kind = k; x.a_real = ar; x.a_imag = ai; x.b_real = br; x.b_imag = bi;
    return x;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 262143) - 131072;
      1: return $urandom_range(0, 131071) - 65536;
      2: case ($urandom_range(0, 4))
           0: return WMAX;
           1: return WMIN;
           2: return 32'd0;
           3: return 32'd1;
           default: return 32'hffffffff;
         endcase
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [2:0] k;
    for (int i = 0; i < 6; i++) begin
      k = i[2:0];
      send_item(make_item(k, WMAX, WMAX, WMIN, WMIN));
      send_item(make_item(k, WMIN, WMAX, WMIN, WMAX));
    end
    send_item(make_item(cau_pkg::KIND_ADD, WMAX, WMIN, 32'd1, 32'hffffffff));
  endtask

  task automatic test_special();
    send_item(make_item(cau_pkg::KIND_DIV, 32'h00010000, 32'h00020000, 32'd0, 32'd0));
    send_item(make_item(cau_pkg::KIND_DIV, WMAX, WMIN, 32'd1, 32'd0));
    send_item(make_item(cau_pkg::KIND_DIV, 32'hffff0000, 32'd3, 32'd0, 32'hffffffff));
    send_item(make_item(cau_pkg::KIND_MUL, 32'hffffffff, 32'd0, 32'd1, 32'd0));
    send_item(make_item(cau_pkg::KIND_MUL, 32'h00010000, 32'h00010000, 32'h00010000,
                        32'hffff0000));
    send_item(make_item(cau_pkg::KIND_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678,
                        32'h9abcdef0));
    send_item(make_item(cau_pkg::KIND_NE, 32'h12345678, 32'h9abcdef0, 32'h12345678,
                        32'h9abcdef0));
    send_item(make_item(cau_pkg::KIND_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678,
                        32'h9abcdef1));
    send_item(make_item(3'd6, WMAX, WMAX, 32'd5, 32'd5));
    send_item(make_item(3'd7, WMIN, 32'd1, 32'd0, 32'd0));
  endtask

  task automatic test_random(input int n);
    cau_pkg::cau_in_t x;
    for (int i = 0; i < n; i++) begin
      x.kind   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
      x.a_real = rand_word();
      x.a_imag = rand_word();
      x.b_real = rand_word();
      x.b_imag = rand_word();
      // compares and divides need matching operands and zero divisors to hit both outcomes
      if ((x.kind == cau_pkg::KIND_EQ || x.kind == cau_pkg::KIND_NE) &&
          $urandom_range(0, 1)) begin
        x.b_real = x.a_real;
        x.b_imag = ($urandom_range(0, 2) == 0) ? rand_word() : x.a_imag;
      end
      if (x.kind == cau_pkg::KIND_DIV && $urandom_range(0, 9) == 0) begin
        x.b_real = 32'd0;
        x.b_imag = ($urandom_range(0, 1) == 0) ? 32'd0 : x.b_imag;
      end
      send_item(x);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special();
    test_random(1350);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
